FILE: hdl/hdfr_pkg.sv
// Package for the hash-delimited frame router.
// Holds frame size, byte codes, route codes and the controller/datapath structs.
// No dependencies.
`default_nettype none
package hdfr_pkg;

  localparam int FRAME_BYTES = 40;
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] MARK_BYTE  = 8'h23;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAG_F = 8'h46;
  localparam logic [7:0] TAG_D = 8'h44;
  localparam logic [7:0] TAG_C = 8'h43;
  localparam logic [7:0] TAG_P = 8'h50;
  localparam logic [7:0] TAG_T = 8'h54;
  localparam logic [7:0] TAG_L = 8'h4C;

  localparam logic [2:0] ROUTE_MSP     = 3'd0;
  localparam logic [2:0] ROUTE_DIMMER  = 3'd1;
  localparam logic [2:0] ROUTE_CURRENT = 3'd2;
  localparam logic [2:0] ROUTE_PIR     = 3'd3;
  localparam logic [2:0] ROUTE_TEMP    = 3'd4;
  localparam logic [2:0] ROUTE_LDR     = 3'd5;

  typedef struct packed {
    logic open;     // frame start: reset fill count and tag
    logic store;    // write word at fill position
    logic idx_clr;  // start emission at position 0
    logic rd;       // read store at emission position
    logic idx_inc;  // step emission position
  } dp_cmd_t;

  typedef struct packed {
    logic is_mark;
    logic full;
    logic route_ok;
    logic is_last;
  } dp_stat_t;

  function automatic logic [2:0] route_of(input logic [7:0] tag);
    logic [2:0] r;
    case (tag)
      TAG_F:   r = ROUTE_MSP;
      TAG_D:   r = ROUTE_DIMMER;
      TAG_C:   r = ROUTE_CURRENT;
      TAG_P:   r = ROUTE_PIR;
      TAG_T:   r = ROUTE_TEMP;
      TAG_L:   r = ROUTE_LDR;
      default: r = ROUTE_MSP;
    endcase
    return r;
  endfunction

  function automatic logic tag_known(input logic [7:0] tag);
    logic k;
    case (tag)
      TAG_F, TAG_D, TAG_C, TAG_P, TAG_T, TAG_L: k = 1'b1;
      default:                                  k = 1'b0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hdfr_if.sv
// Valid/ready channel interfaces for the frame router.
// Depends on nothing; payload widths are fixed by the frame format.
`default_nettype none
interface hdfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hdfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] route;
  logic [7:0] payload_byte;
  logic       last;
  modport source (output valid, output route, output payload_byte, output last, input ready);
  modport sink (input valid, input route, input payload_byte, input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/hdfr_ctrl.sv
// Frame router controller: idle / fill / read / send state machine.
// Depends on hdfr_pkg for command and status structs.
`default_nettype none
module hdfr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire hdfr_pkg::dp_stat_t stat,
  output hdfr_pkg::dp_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       acc;

  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (acc && stat.is_mark) begin
          cmd.open  = 1'b1;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        in_ready = 1'b1;
        if (acc) begin
          if (!stat.is_mark && !stat.full) begin
            cmd.store = 1'b1;
          end else if (stat.route_ok) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hdfr_dpath.sv
// Frame router datapath: frame store memory, fill count, tag and emission index.
// Depends on hdfr_pkg; entries past the fill count read as zero.
`default_nettype none
module hdfr_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        rx_byte,
  input  wire hdfr_pkg::dp_cmd_t cmd,
  output hdfr_pkg::dp_stat_t     stat,
  output logic [2:0]             route,
  output logic [7:0]             payload_byte,
  output logic                   last
);

  logic [7:0]                 mem [hdfr_pkg::FRAME_BYTES];
  logic [hdfr_pkg::CNT_W-1:0] fill_r;
  logic [hdfr_pkg::IDX_W-1:0] idx_r;
  logic [7:0]                 tag_r;
  logic [7:0]                 rd_data_r;
  logic                       first_r;
  logic                       pad_r;
  logic                       last_r;

  assign stat.is_mark  = (rx_byte == hdfr_pkg::MARK_BYTE);
  assign stat.full     = (fill_r == hdfr_pkg::CNT_W'(hdfr_pkg::FRAME_BYTES));
  assign stat.route_ok = hdfr_pkg::tag_known(tag_r);
  assign stat.is_last  = last_r;

  assign route        = hdfr_pkg::route_of(tag_r);
  assign payload_byte = first_r ? hdfr_pkg::SPACE_BYTE : (pad_r ? 8'h00 : rd_data_r);
  assign last         = last_r;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill_r[hdfr_pkg::IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      idx_r   <= '0;
      tag_r   <= '0;
      first_r <= 1'b0;
      pad_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      if (cmd.open) begin
        fill_r <= '0;
        tag_r  <= '0;
      end else if (cmd.store) begin
        fill_r <= fill_r + 1'b1;
        if (fill_r == '0) begin
          tag_r <= rx_byte;
        end
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.rd) begin
        first_r <= (idx_r == '0);
        pad_r   <= (hdfr_pkg::CNT_W'(idx_r) >= fill_r) ? 1'b1 : 1'b0;
        last_r  <= (idx_r == hdfr_pkg::IDX_W'(hdfr_pkg::FRAME_BYTES - 1));
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hash_delimited_frame_router_top.sv
// Hash-delimited frame router top: '#'-framed byte capture, tag lookup, burst emit.
// Input is accepted whenever the router is idle or filling; a frame with a known tag
// ends in a burst of FRAME_BYTES output words, each a store read and then a send that
// waits for out_ready. Input is held off during the burst. Synchronous active-low reset
// returns to idle. Depends on hdfr_pkg, hdfr_if, hdfr_ctrl and hdfr_dpath.
`default_nettype none
module hash_delimited_frame_router_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hdfr_in_if.sink    in_ch,
  hdfr_out_if.source out_ch
);

  hdfr_pkg::dp_cmd_t  cmd;
  hdfr_pkg::dp_stat_t stat;

  hdfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hdfr_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_ch.rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .route        (out_ch.route),
    .payload_byte (out_ch.payload_byte),
    .last         (out_ch.last)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for hash_delimited_frame_router_top: drives '#'-framed byte streams and
// checks every emitted word against a behavioral frame predictor. Depends on hdfr_pkg,
// hdfr_if and the router RTL.
module testbench;

  typedef struct packed {
    logic [2:0] route;
    logic [7:0] data;
    logic       last;
  } route_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hdfr_in_if  in_ch();
  hdfr_out_if out_ch();

  hash_delimited_frame_router_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // frame predictor state
  bit          frame_open;
  int          stored_count;
  logic [7:0]  frame_buf [hdfr_pkg::FRAME_BYTES];
  route_word_t pending_words [$];

  int  mismatch_count;
  int  counted_bytes;
  bit  src_gaps_on;
  bit  sink_stalls_on;

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    frame_open     = 1'b0;
    stored_count   = 0;
    mismatch_count = 0;
    counted_bytes  = 0;
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
  end

  always @(negedge clk) begin
    out_ch.ready <= !(sink_stalls_on && $urandom_range(0, 99) < 23);
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic bit lookup_route(input logic [7:0] tag, output logic [2:0] route);
    bit known;
    known = 1'b1;
    case (tag)
      hdfr_pkg::TAG_F: route = hdfr_pkg::ROUTE_MSP;
      hdfr_pkg::TAG_D: route = hdfr_pkg::ROUTE_DIMMER;
      hdfr_pkg::TAG_C: route = hdfr_pkg::ROUTE_CURRENT;
      hdfr_pkg::TAG_P: route = hdfr_pkg::ROUTE_PIR;
      hdfr_pkg::TAG_T: route = hdfr_pkg::ROUTE_TEMP;
      hdfr_pkg::TAG_L: route = hdfr_pkg::ROUTE_LDR;
      default: begin
        route = hdfr_pkg::ROUTE_MSP;
        known = 1'b0;
      end
    endcase
    return known;
  endfunction

  task automatic predict_frame_byte(input logic [7:0] b);
    logic [2:0]  route;
    route_word_t w;
    if (!frame_open) begin
      if (b == hdfr_pkg::MARK_BYTE) begin
        frame_open   = 1'b1;
        stored_count = 0;
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        counted_bytes++;
      end
    end else if (b != hdfr_pkg::MARK_BYTE && stored_count < hdfr_pkg::FRAME_BYTES) begin
      frame_buf[stored_count] = b;
      stored_count++;
      counted_bytes++;
    end else begin
      frame_open = 1'b0;
      counted_bytes++;
      if (lookup_route(frame_buf[0], route)) begin
        for (int k = 0; k < hdfr_pkg::FRAME_BYTES; k++) begin
          w.route = route;
          w.data  = (k == 0) ? hdfr_pkg::SPACE_BYTE : frame_buf[k];
          w.last  = (k == hdfr_pkg::FRAME_BYTES - 1);
          pending_words.push_back(w);
        end
      end
    end
  endtask

  // one input word; valid stays high across back-to-back words
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (src_gaps_on && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame_byte(b);
  endtask

  always @(posedge clk) begin
    route_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word route=%0d data=%02h last=%0b",
                                  out_ch.route, out_ch.payload_byte, out_ch.last));
      end else begin
        w = pending_words.pop_front();
        if (out_ch.route !== w.route)
          report_mismatch($sformatf("route %0d, want %0d", out_ch.route, w.route));
        if (out_ch.payload_byte !== w.data)
          report_mismatch($sformatf("payload %02h, want %02h", out_ch.payload_byte, w.data));
        if (out_ch.last !== w.last)
          report_mismatch($sformatf("last %0b, want %0b", out_ch.last, w.last));
      end
    end
  end

  function automatic logic [7:0] pick_tag();
    logic [7:0] t;
    case ($urandom_range(0, 5))
      0:       t = hdfr_pkg::TAG_F;
      1:       t = hdfr_pkg::TAG_D;
      2:       t = hdfr_pkg::TAG_C;
      3:       t = hdfr_pkg::TAG_P;
      4:       t = hdfr_pkg::TAG_T;
      default: t = hdfr_pkg::TAG_L;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == hdfr_pkg::MARK_BYTE && $urandom_range(0, 3) != 0) b = 8'h24;
    if ($urandom_range(0, 99) == 0) b = hdfr_pkg::MARK_BYTE;
    return b;
  endfunction

  // body_len counts bytes after the tag; FRAME_BYTES-1 fills the store
  task automatic send_frame(input logic [7:0] tag, input int body_len, input bit end_on_mark);
    logic [7:0] b;
    if (frame_open) send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(tag);
    for (int i = 0; i < body_len; i++) send_byte(body_byte());
    if (end_on_mark) begin
      send_byte(hdfr_pkg::MARK_BYTE);
    end else begin
      b = 8'($urandom_range(0, 255));
      if (b == hdfr_pkg::MARK_BYTE) b = 8'h55;
      send_byte(b);
    end
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h22);
    send_byte(8'h24);
  endtask

  task automatic test_each_route();
    logic [7:0] tags [5];
    tags = '{hdfr_pkg::TAG_D, hdfr_pkg::TAG_C, hdfr_pkg::TAG_P, hdfr_pkg::TAG_T,
             hdfr_pkg::TAG_L};
    send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(hdfr_pkg::TAG_F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(hdfr_pkg::MARK_BYTE);
    foreach (tags[i]) begin
      send_byte(hdfr_pkg::MARK_BYTE);
      send_byte(tags[i]);
      send_byte(hdfr_pkg::MARK_BYTE);
    end
  endtask

  task automatic test_empty_and_unknown();
    // empty frame; then a tag that would route only if the closing mark reopened
    send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(hdfr_pkg::TAG_D);
    send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(hdfr_pkg::MARK_BYTE);
    send_byte(8'h66);
    send_byte(hdfr_pkg::MARK_BYTE);
  endtask

  task automatic test_random_frames(input int target);
    int pick;
    int len;
    send_frame(pick_tag(), hdfr_pkg::FRAME_BYTES - 1, 1'b0);
    send_frame(pick_tag(), hdfr_pkg::FRAME_BYTES - 1, 1'b1);
    while (counted_bytes < target) begin
      src_gaps_on    = !(counted_bytes >= 200 && counted_bytes < 300);
      sink_stalls_on = src_gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(body_byte());
      end else begin
        len = ($urandom_range(0, 4) == 0)
              ? $urandom_range(hdfr_pkg::FRAME_BYTES - 3, hdfr_pkg::FRAME_BYTES - 1)
              : $urandom_range(0, 12);
        send_frame(($urandom_range(0, 9) < 8) ? pick_tag() : 8'($urandom_range(0, 255)),
                   len, !(len == hdfr_pkg::FRAME_BYTES - 1 && $urandom_range(0, 1) == 1));
      end
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic drain_outputs();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_ignored_bytes();
    test_each_route();
    test_empty_and_unknown();
    test_random_frames(430);
    drain_outputs();
    if (mismatch_count == 0) begin
      $display("hash_delimited_frame_router_top verification clean");
    end else begin
      $display("hash_delimited_frame_router_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("hash_delimited_frame_router_top verification failed");
    $finish;
  end

endmodule
